>>> hdl/light_mode_stepdown_controller_defines.svh
// assertion macros for the light mode controller checker
`ifndef LIGHT_MODE_STEPDOWN_CONTROLLER_DEFINES_SVH
`define LIGHT_MODE_STEPDOWN_CONTROLLER_DEFINES_SVH

// same-cycle implication, held off during reset
`define LMSC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define LMSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/lmsc_pkg.sv
// types, constants and result formatting for the light mode controller
`timescale 1ns / 1ps

package lmsc_pkg;

  // mode indexes
  localparam logic [2:0] MODE_ZERO  = 3'd0;
  localparam logic [2:0] MODE_TWO   = 3'd2;
  localparam logic [2:0] MODE_TURBO = 3'd3;
  localparam logic [2:0] MODE_LAST  = 3'd6;
  localparam logic [2:0] MODE_BAD   = 3'd7;

  // result queue depth: room for one request in flight plus a two-result item
  localparam int unsigned RES_DEPTH = 3;

  // battery check thresholds
  localparam logic [7:0] BLINK_TAB [9] = '{8'd121, 8'd137, 8'd147, 8'd158, 8'd163,
                                           8'd168, 8'd173, 8'd178, 8'd184};

  // register reset values
  localparam logic       MEM_EN_RST     = 1'b1;
  localparam logic [7:0] SHORT_LVL_RST  = 8'd115;
  localparam logic       MED_EN_RST     = 1'b0;
  localparam logic [7:0] MED_LVL_RST    = 8'd94;
  localparam logic [7:0] TURBO_TO_RST   = 8'd90;
  localparam logic [7:0] LOW_VOLT_RST   = 8'd121;
  localparam logic [3:0] LOW_LIMIT_RST  = 4'd8;

  typedef enum logic [2:0] {
    CFG_MEM_EN    = 3'd0,
    CFG_SHORT_LVL = 3'd1,
    CFG_MED_EN    = 3'd2,
    CFG_MED_LVL   = 3'd3,
    CFG_TURBO_TO  = 3'd4,
    CFG_LOW_VOLT  = 3'd5,
    CFG_LOW_LIMIT = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PAT_SOLID  = 3'd0,
    PAT_STROBE = 3'd1,
    PAT_BIKE   = 3'd2,
    PAT_BATT   = 3'd3,
    PAT_OFF    = 3'd4
  } pattern_e;

  typedef enum logic {
    ACT_POWER_UP = 1'b0,
    ACT_PASS     = 1'b1
  } action_e;

  typedef struct packed {
    logic       mem_en;
    logic [7:0] short_lvl;
    logic       med_en;
    logic [7:0] med_lvl;
    logic [7:0] turbo_to;
    logic [7:0] low_volt;
    logic [3:0] low_limit;
  } cfg_t;

  typedef struct packed {
    logic       action;
    logic [7:0] press_level;
    logic [2:0] saved_mode;
    logic [6:0] saved_slot;
    logic [7:0] voltage_sample;
    logic       voltage_ready;
  } item_t;

  typedef struct packed {
    logic [2:0] mode_now;
    logic [7:0] main_level;
    logic [7:0] aux_level;
    logic       fast_pwm;
    pattern_e   pattern;
    logic [3:0] blink_count;
    logic       save_write;
    logic [5:0] save_address;
    logic       erase_valid;
    logic [5:0] erase_address;
    logic       powered_down;
    logic       last_result;
  } result_t;

  // request into the result queue: one or two results
  typedef struct packed {
    logic valid;
    logic two;
  } push_t;

  // builds one result for the given mode and save details
  function automatic result_t make_result(logic [2:0] mode, logic shut, logic save,
                                          logic [5:0] new_addr, logic old_ok,
                                          logic [5:0] old_addr, logic [7:0] volt);
    result_t     r;
    logic [3:0]  blinks;
    logic [2:0]  m;
    r      = '0;
    blinks = '0;
    m      = (mode == MODE_BAD) ? MODE_ZERO : mode;
    r.mode_now = m;
    r.pattern  = PAT_SOLID;
    if (shut) begin
      r.pattern      = PAT_OFF;
      r.powered_down = 1'b1;
    end else begin
      unique case (m)
        3'd0:    begin r.main_level = 8'd0;   r.aux_level = 8'd3;   end
        3'd1:    begin r.main_level = 8'd7;   r.aux_level = 8'd110; r.fast_pwm = 1'b1; end
        3'd2:    begin r.main_level = 8'd137; r.aux_level = 8'd255; r.fast_pwm = 1'b1; end
        3'd3:    begin r.main_level = 8'd255; r.aux_level = 8'd0;   end
        3'd4:    r.pattern = PAT_STROBE;
        3'd5:    r.pattern = PAT_BIKE;
        3'd6:    r.pattern = PAT_BATT;
        default: r.pattern = PAT_SOLID;
      endcase
      if (r.pattern == PAT_BATT) begin
        for (int i = 0; i < 9; i++) begin
          if (volt > BLINK_TAB[i]) blinks = blinks + 4'd1;
        end
      end
      r.blink_count = blinks;
    end
    if (save) begin
      r.save_write   = 1'b1;
      r.save_address = new_addr;
      if (old_ok) begin
        r.erase_valid   = 1'b1;
        r.erase_address = old_addr;
      end
    end
    return r;
  endfunction

endpackage

>>> hdl/light_mode_stepdown_controller.sv
// top level of the two-channel LED driver mode controller
//
//   channel | signals                          | carries
//   --------+----------------------------------+----------------------------------
//   in      | in_valid_i / in_ready_o          | power-up or loop-pass request
//   out     | out_valid_o / out_ready_i        | one result: levels, mode, save
//   cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i | register write, no wait
//
// one request a cycle while the queue has room: the input register feeds the
// mode update, which pushes its results into a three-entry queue, so a taken
// request passes the input register and then the queue before its first result
// is offered. a request that steps down twice gives two results.
// reset clears mode, slot and counters; no clearing pass.
// a stalled output side fills the queue, then in_ready_o falls.
`timescale 1ns / 1ps

module light_mode_stepdown_controller #(
  parameter int unsigned SAVE_SLOTS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       action_i,
  input  logic [7:0] press_level_i,
  input  logic [2:0] saved_mode_i,
  input  logic [6:0] saved_slot_i,
  input  logic [7:0] voltage_sample_i,
  input  logic       voltage_ready_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] mode_now_o,
  output logic [7:0] main_level_o,
  output logic [7:0] aux_level_o,
  output logic       fast_pwm_o,
  output logic [2:0] pattern_o,
  output logic [3:0] blink_count_o,
  output logic       save_write_o,
  output logic [5:0] save_address_o,
  output logic       erase_valid_o,
  output logic [5:0] erase_address_o,
  output logic       powered_down_o,
  output logic       last_result_o
);
  import lmsc_pkg::*;

  cfg_t    cfg_q;
  item_t   item_q;
  logic    in_valid_q;
  logic    fire, room;
  push_t   push;
  result_t res0, res1, head;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mem_en: MEM_EN_RST, short_lvl: SHORT_LVL_RST, med_en: MED_EN_RST,
                 med_lvl: MED_LVL_RST, turbo_to: TURBO_TO_RST, low_volt: LOW_VOLT_RST,
                 low_limit: LOW_LIMIT_RST};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MEM_EN:    cfg_q.mem_en    <= cfg_wdata_i[0];
        CFG_SHORT_LVL: cfg_q.short_lvl <= cfg_wdata_i;
        CFG_MED_EN:    cfg_q.med_en    <= cfg_wdata_i[0];
        CFG_MED_LVL:   cfg_q.med_lvl   <= cfg_wdata_i;
        CFG_TURBO_TO:  cfg_q.turbo_to  <= cfg_wdata_i;
        CFG_LOW_VOLT:  cfg_q.low_volt  <= cfg_wdata_i;
        CFG_LOW_LIMIT: cfg_q.low_limit <= cfg_wdata_i[3:0];
        default:       cfg_q           <= cfg_q;
      endcase
    end
  end

  // input register
  assign fire       = in_valid_q && room;
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= '{action: action_i, press_level: press_level_i, saved_mode: saved_mode_i,
                  saved_slot: saved_slot_i, voltage_sample: voltage_sample_i,
                  voltage_ready: voltage_ready_i};
    end
  end

  // mode update
  lmsc_core #(
    .SAVE_SLOTS (SAVE_SLOTS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .push_o (push),
    .res0_o (res0),
    .res1_o (res1)
  );

  // result queue
  lmsc_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res0_i      (res0),
    .res1_i      (res1),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  // result fields
  assign mode_now_o      = head.mode_now;
  assign main_level_o    = head.main_level;
  assign aux_level_o     = head.aux_level;
  assign fast_pwm_o      = head.fast_pwm;
  assign pattern_o       = head.pattern;
  assign blink_count_o   = head.blink_count;
  assign save_write_o    = head.save_write;
  assign save_address_o  = head.save_address;
  assign erase_valid_o   = head.erase_valid;
  assign erase_address_o = head.erase_address;
  assign powered_down_o  = head.powered_down;
  assign last_result_o   = head.last_result;

endmodule

>>> hdl/lmsc_core.sv
// mode state registers and the single-pass update for one request
`timescale 1ns / 1ps

module lmsc_core #(
  parameter int unsigned SAVE_SLOTS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  lmsc_pkg::item_t  item_i,
  input  lmsc_pkg::cfg_t   cfg_i,
  output lmsc_pkg::push_t  push_o,
  output lmsc_pkg::result_t res0_o,
  output lmsc_pkg::result_t res1_o
);
  import lmsc_pkg::*;

  localparam int unsigned SlotW = $clog2(SAVE_SLOTS + 1);
  localparam int unsigned CmpW  = (SlotW > 7) ? SlotW : 7;
  localparam logic [SlotW:0]  SlotsExt = (SlotW + 1)'(SAVE_SLOTS);
  localparam logic [SlotW-1:0] NoSlot  = SlotW'(SAVE_SLOTS);

  // next wear slot, modulo the slot count
  function automatic logic [SlotW-1:0] slot_next(logic [SlotW-1:0] w);
    logic [SlotW:0] s;
    s = {1'b0, w} + 1'b1;
    if (s >= SlotsExt) s = s - SlotsExt;
    return s[SlotW-1:0];
  endfunction

  function automatic logic slot_ok(logic [SlotW-1:0] w);
    return {1'b0, w} < SlotsExt;
  endfunction

  logic [2:0]       mode_q, mode_d;
  logic [SlotW-1:0] wear_q, wear_d;
  logic [7:0]       ticks_q, ticks_d;
  logic [3:0]       low_q, low_d;
  logic             shut_q, shut_d;

  logic             slot_found;
  logic [2:0]       rest_mode, mode_a, mode_pu, mode1, mode2;
  logic [SlotW-1:0] wear_a, wear1, wear2;
  logic [7:0]       ticks_inc;
  logic             turbo, trig, shut2;
  logic [3:0]       low_sat, low1;
  result_t          res_pu, res_a, res_b, res_idle;

  // power-up: restore slot and mode, then apply the press length
  assign slot_found = CmpW'(item_i.saved_slot) < CmpW'(SAVE_SLOTS);
  assign rest_mode  = (item_i.saved_mode == MODE_BAD) ? MODE_ZERO : item_i.saved_mode;
  assign mode_a     = slot_found ? rest_mode : mode_q;
  assign wear_a     = slot_found ? SlotW'(item_i.saved_slot) : NoSlot;

  always_comb begin
    priority if (item_i.press_level > cfg_i.short_lvl) begin
      mode_pu = (mode_a >= MODE_LAST) ? MODE_ZERO : mode_a + 3'd1;
    end else if (cfg_i.med_en && item_i.press_level > cfg_i.med_lvl) begin
      mode_pu = (mode_a == MODE_ZERO) ? MODE_LAST : mode_a - 3'd1;
    end else if (!cfg_i.mem_en) begin
      mode_pu = MODE_ZERO;
    end else begin
      mode_pu = mode_a;
    end
  end

  // loop pass: turbo timeout step
  assign ticks_inc = ticks_q + 8'd1;
  assign turbo     = (mode_q == MODE_TURBO) && (ticks_inc > cfg_i.turbo_to);
  assign mode1     = turbo ? MODE_TWO : mode_q;
  assign wear1     = turbo ? slot_next(wear_q) : wear_q;

  // loop pass: low battery count and step down
  assign low_sat = (low_q == 4'hf) ? low_q : low_q + 4'd1;
  assign low1    = (item_i.voltage_sample < cfg_i.low_volt) ? low_sat : 4'd0;
  assign trig    = item_i.voltage_ready && (low1 >= cfg_i.low_limit);
  assign shut2   = (mode1 == MODE_ZERO);
  assign mode2   = (mode1 >= MODE_TURBO) ? MODE_TWO :
                   (mode1 == MODE_ZERO) ? MODE_ZERO : mode1 - 3'd1;
  assign wear2   = (trig && !shut2) ? slot_next(wear1) : wear1;

  // candidate results
  assign res_pu   = make_result(mode_pu, 1'b0, 1'b1, 6'(slot_next(wear_a)),
                                slot_ok(wear_a), 6'(wear_a), item_i.voltage_sample);
  assign res_a    = make_result(mode1, 1'b0, 1'b1, 6'(wear1), slot_ok(wear_q),
                                6'(wear_q), item_i.voltage_sample);
  assign res_b    = make_result(mode2, shut2, !shut2, 6'(wear2), slot_ok(wear1),
                                6'(wear1), item_i.voltage_sample);
  assign res_idle = make_result(mode_q, shut_q, 1'b0, 6'd0, 1'b0, 6'd0,
                                item_i.voltage_sample);

  // next state and results for the request
  always_comb begin
    mode_d  = mode_q;
    wear_d  = wear_q;
    ticks_d = ticks_q;
    low_d   = low_q;
    shut_d  = shut_q;
    push_o  = '{valid: fire_i, two: 1'b0};
    res0_o  = res_idle;
    res1_o  = res_b;
    if (item_i.action == ACT_POWER_UP) begin
      mode_d  = mode_pu;
      wear_d  = slot_next(wear_a);
      ticks_d = '0;
      low_d   = '0;
      shut_d  = 1'b0;
      res0_o  = res_pu;
    end else if (!shut_q) begin
      if (mode_q <= MODE_TURBO) ticks_d = ticks_inc;
      if (item_i.voltage_ready) low_d = trig ? 4'd0 : low1;
      mode_d = trig ? mode2 : mode1;
      shut_d = trig && shut2;
      wear_d = wear2;
      if (turbo) begin
        res0_o = res_a;
      end else if (trig) begin
        res0_o = res_b;
      end
      push_o.two = turbo && trig;
    end
    res0_o.last_result = !push_o.two;
    res1_o.last_result = 1'b1;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_ZERO;
      wear_q  <= NoSlot;
      ticks_q <= '0;
      low_q   <= '0;
      shut_q  <= 1'b0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      wear_q  <= wear_d;
      ticks_q <= ticks_d;
      low_q   <= low_d;
      shut_q  <= shut_d;
    end
  end

endmodule

>>> hdl/lmsc_result_fifo.sv
// three-entry result queue that takes one or two results per request
`timescale 1ns / 1ps

module lmsc_result_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lmsc_pkg::push_t   push_i,
  input  lmsc_pkg::result_t res0_i,
  input  lmsc_pkg::result_t res1_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lmsc_pkg::result_t head_o
);
  import lmsc_pkg::*;

  result_t    q_q [RES_DEPTH];
  result_t    q_d [RES_DEPTH];
  logic [1:0] cnt_q, cnt_d, cnt_pop;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign head_o      = q_q[0];
  assign pop         = out_valid_o && out_ready_i;
  assign cnt_pop     = cnt_q - {1'b0, pop};
  // room for a two-result request regardless of the output side
  assign room_o      = (cnt_q <= 2'd1);

  assign cnt_d = cnt_pop + {1'b0, push_i.valid} + {1'b0, push_i.valid & push_i.two};

  // per entry: shift on pop, then land new results behind the survivors
  for (genvar i = 0; i < RES_DEPTH; i++) begin : g_ent
    result_t shifted;
    if (i < RES_DEPTH - 1) begin : g_shift
      assign shifted = pop ? q_q[i+1] : q_q[i];
    end else begin : g_tail
      assign shifted = q_q[i];
    end
    always_comb begin
      q_d[i] = shifted;
      if (push_i.valid && cnt_pop == 2'(i)) begin
        q_d[i] = res0_i;
      end else if (push_i.valid && push_i.two && (cnt_pop + 2'd1) == 2'(i)) begin
        q_d[i] = res1_i;
      end
    end
    always_ff @(posedge clk_i) begin
      q_q[i] <= q_d[i];
    end
  end

  // occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> hdl/lmsc_checker.sv
// port-level checks on the light mode controller, bound to the top level
`timescale 1ns / 1ps
`include "light_mode_stepdown_controller_defines.svh"

module lmsc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] mode_now_o,
  input logic [7:0] main_level_o,
  input logic [7:0] aux_level_o,
  input logic [2:0] pattern_o,
  input logic [3:0] blink_count_o,
  input logic       save_write_o,
  input logic [5:0] save_address_o,
  input logic       erase_valid_o,
  input logic       powered_down_o
);
  import lmsc_pkg::*;

  // a stalled result stays valid and holds its mode and save address
  `LMSC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(mode_now_o) && $stable(save_address_o), "result changed while stalled")

  // no save means a zero save address and no erase
  `LMSC_ASSERT_NOW(a_save_clean, clk_i, rst_ni, out_valid_o && !save_write_o, save_address_o == 6'd0 && !erase_valid_o, "stray save fields")

  // an off result drives nothing and saves nothing
  `LMSC_ASSERT_NOW(a_off_dark, clk_i, rst_ni, out_valid_o && powered_down_o, pattern_o == PAT_OFF && main_level_o == 8'd0 && aux_level_o == 8'd0 && !save_write_o, "off result not dark")

  // blinks only in battery check
  `LMSC_ASSERT_NOW(a_blink_batt, clk_i, rst_ni, out_valid_o && pattern_o != PAT_BATT, blink_count_o == 4'd0, "blinks outside battery check")

endmodule

bind light_mode_stepdown_controller lmsc_checker u_lmsc_checker (.*);
